>>> sv/osl_pkg.sv
// ----------------------------------------------------------------------------
// osl_pkg
// Shared types, codes and the character classifier for the operator and
// string lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package osl_pkg;

    localparam int LINE_WIDTH_DEF   = 16;
    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 2;

    typedef logic [4:0] t_kind;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_PENDING = 2'd1,
        MODE_STRING  = 2'd2,
        MODE_DROP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_BANG    = 2'd0,
        OP_EQUAL   = 2'd1,
        OP_LESS    = 2'd2,
        OP_GREATER = 2'd3
    } t_op;

    localparam t_kind KIND_LPAREN       = 5'd0;
    localparam t_kind KIND_RPAREN       = 5'd1;
    localparam t_kind KIND_LBRACE       = 5'd2;
    localparam t_kind KIND_RBRACE       = 5'd3;
    localparam t_kind KIND_COMMA        = 5'd4;
    localparam t_kind KIND_DOT          = 5'd5;
    localparam t_kind KIND_MINUS        = 5'd6;
    localparam t_kind KIND_PLUS         = 5'd7;
    localparam t_kind KIND_SEMICOLON    = 5'd8;
    localparam t_kind KIND_STAR         = 5'd9;
    localparam t_kind KIND_BANG         = 5'd10;
    localparam t_kind KIND_STRING       = 5'd18;
    localparam t_kind KIND_UNEXPECTED   = 5'd19;
    localparam t_kind KIND_UNTERMINATED = 5'd20;

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;

    // classification of one byte in normal mode
    typedef struct packed {
        logic  emit;
        t_kind kind;
        logic  to_pending;
        t_op   op;
        logic  to_string;
        logic  newline;
        logic  to_drop;
    } t_scan;

    // control part of one queued word
    typedef struct packed {
        logic  two;
        t_kind kind0;
        t_kind kind1;
    } t_ctl;

    function automatic t_kind op_kind(input t_op op, input logic with_equal);
        op_kind = KIND_BANG + {2'b00, op, with_equal};
    endfunction

    function automatic t_scan scan_char(input logic [7:0] c);
        t_scan s;
        s = '0;
        unique case (c) inside
            CH_LPAREN:  begin s.emit = 1'b1; s.kind = KIND_LPAREN;    end
            CH_RPAREN:  begin s.emit = 1'b1; s.kind = KIND_RPAREN;    end
            CH_LBRACE:  begin s.emit = 1'b1; s.kind = KIND_LBRACE;    end
            CH_RBRACE:  begin s.emit = 1'b1; s.kind = KIND_RBRACE;    end
            CH_COMMA:   begin s.emit = 1'b1; s.kind = KIND_COMMA;     end
            CH_DOT:     begin s.emit = 1'b1; s.kind = KIND_DOT;       end
            CH_MINUS:   begin s.emit = 1'b1; s.kind = KIND_MINUS;     end
            CH_PLUS:    begin s.emit = 1'b1; s.kind = KIND_PLUS;      end
            CH_SEMI:    begin s.emit = 1'b1; s.kind = KIND_SEMICOLON; end
            CH_STAR:    begin s.emit = 1'b1; s.kind = KIND_STAR;      end
            CH_BANG:    begin s.to_pending = 1'b1; s.op = OP_BANG;    end
            CH_EQUAL:   begin s.to_pending = 1'b1; s.op = OP_EQUAL;   end
            CH_LESS:    begin s.to_pending = 1'b1; s.op = OP_LESS;    end
            CH_GREATER: begin s.to_pending = 1'b1; s.op = OP_GREATER; end
            CH_QUOTE:   s.to_string = 1'b1;
            CH_SPACE, CH_CR, CH_TAB: s.emit = 1'b0;
            CH_NL:      s.newline = 1'b1;
            default: begin
                s.emit    = 1'b1;
                s.kind    = KIND_UNEXPECTED;
                s.to_drop = 1'b1;
            end
        endcase
        scan_char = s;
    endfunction

endpackage

`default_nettype wire

>>> sv/operator_string_lexer_top.sv
// ----------------------------------------------------------------------------
// operator_string_lexer_top
// Scanner for punctuators, comparison operators and quoted strings with
// line tracking; one source byte per word in, one token per word out.
// path: each token is registered in the queue and then in the output register
// throughput: one byte per cycle while the queue has space; a byte that yields
// two tokens is one queue word, and the single output register shows them in turn
// reset: scan state to normal mode at line 1, queue and output stage empty
// ----------------------------------------------------------------------------
`default_nettype none

module operator_string_lexer_top #(
    parameter int LINE_WIDTH   = osl_pkg::LINE_WIDTH_DEF,
    parameter int LENGTH_WIDTH = osl_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [7:0]              i_char_code,
    input  wire logic                    i_end_of_source,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [4:0]                   o_token_kind,
    output logic [LINE_WIDTH-1:0]        o_line_number,
    output logic [LENGTH_WIDTH-1:0]      o_string_length,
    output logic                         o_last_of_run
);

    localparam int CW = $bits(osl_pkg::t_ctl);
    localparam int QW = CW + LINE_WIDTH + LENGTH_WIDTH;

    logic                    push, pop, space, avail;
    osl_pkg::t_ctl           f_ctl, b_ctl;
    logic [LINE_WIDTH-1:0]   f_line, b_line;
    logic [LENGTH_WIDTH-1:0] f_len, b_len;
    logic [QW-1:0]           q_in, q_out;

    osl_front #(
        .LINE_WIDTH   (LINE_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_char_code     (i_char_code),
        .i_end_of_source (i_end_of_source),
        .i_space         (space),
        .o_ready         (o_ready),
        .o_push          (push),
        .o_ctl           (f_ctl),
        .o_line          (f_line),
        .o_length        (f_len)
    );

    assign q_in = {f_ctl, f_line, f_len};

    osl_queue #(
        .WIDTH (QW),
        .DEPTH (osl_pkg::QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_space (space),
        .o_avail (avail),
        .o_data  (q_out),
        .i_pop   (pop)
    );

    assign b_ctl  = q_out[QW-1 -: CW];
    assign b_line = q_out[LINE_WIDTH+LENGTH_WIDTH-1 -: LINE_WIDTH];
    assign b_len  = q_out[LENGTH_WIDTH-1:0];

    osl_back #(
        .LINE_WIDTH   (LINE_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (avail),
        .i_ctl           (b_ctl),
        .i_line          (b_line),
        .i_length        (b_len),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_token_kind    (o_token_kind),
        .o_line_number   (o_line_number),
        .o_string_length (o_string_length),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

`default_nettype wire

>>> sv/osl_front.sv
// ----------------------------------------------------------------------------
// osl_front
// Scanner front end: holds the scan state, classifies each byte and forms
// one queue word holding the one or two tokens the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module osl_front #(
    parameter int LINE_WIDTH   = osl_pkg::LINE_WIDTH_DEF,
    parameter int LENGTH_WIDTH = osl_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [7:0]              i_char_code,
    input  wire logic                    i_end_of_source,
    input  wire logic                    i_space,
    output logic                         o_ready,
    output logic                         o_push,
    output osl_pkg::t_ctl                o_ctl,
    output logic [LINE_WIDTH-1:0]        o_line,
    output logic [LENGTH_WIDTH-1:0]      o_length
);

    osl_pkg::t_mode            r_mode, n_mode, m1;
    osl_pkg::t_op              r_op, n_op, p1;
    logic [LINE_WIDTH-1:0]     r_line, n_line, l1, line_inc;
    logic [LENGTH_WIDTH-1:0]   r_cnt, n_cnt, s1, cnt_inc;
    osl_pkg::t_scan            sc;
    logic                      is_eq, is_quote, is_nl, take;
    logic                      a_v, b_v, c_v;
    osl_pkg::t_kind            a_k, b_k, c_k;

    assign sc       = osl_pkg::scan_char(i_char_code);
    assign is_eq    = (i_char_code == osl_pkg::CH_EQUAL);
    assign is_quote = (i_char_code == osl_pkg::CH_QUOTE);
    assign is_nl    = (i_char_code == osl_pkg::CH_NL);
    assign line_inc = (r_line == '1) ? r_line : r_line + 1'b1;
    assign cnt_inc  = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
    assign o_ready  = i_space;
    assign take     = i_valid && i_space;

    // next state
    always_comb begin
        m1 = r_mode;
        p1 = r_op;
        l1 = r_line;
        s1 = r_cnt;
        unique case (r_mode) inside
            osl_pkg::MODE_NORMAL, osl_pkg::MODE_PENDING: begin
                if (r_mode == osl_pkg::MODE_PENDING && is_eq) begin
                    m1 = osl_pkg::MODE_NORMAL;
                end else begin
                    m1 = osl_pkg::MODE_NORMAL;
                    if (sc.to_pending) begin
                        m1 = osl_pkg::MODE_PENDING;
                        p1 = sc.op;
                    end
                    if (sc.to_string) begin
                        m1 = osl_pkg::MODE_STRING;
                        s1 = '0;
                    end
                    if (sc.newline) begin
                        l1 = line_inc;
                    end
                    if (sc.to_drop) begin
                        m1 = osl_pkg::MODE_DROP;
                    end
                end
            end
            osl_pkg::MODE_STRING: begin
                if (is_quote) begin
                    m1 = osl_pkg::MODE_NORMAL;
                    s1 = '0;
                end else begin
                    if (is_nl) begin
                        l1 = line_inc;
                    end
                    s1 = cnt_inc;
                end
            end
            osl_pkg::MODE_DROP: m1 = osl_pkg::MODE_DROP;
            default: m1 = r_mode;
        endcase
        if (i_end_of_source) begin
            n_mode = osl_pkg::MODE_NORMAL;
            n_op   = osl_pkg::OP_BANG;
            n_line = LINE_WIDTH'(1);
            n_cnt  = '0;
        end else begin
            n_mode = m1;
            n_op   = p1;
            n_line = l1;
            n_cnt  = s1;
        end
    end

    // tokens of this byte
    always_comb begin
        a_v = 1'b0;
        a_k = '0;
        b_v = 1'b0;
        b_k = '0;
        unique case (r_mode)
            osl_pkg::MODE_NORMAL: begin
                a_v = sc.emit;
                a_k = sc.kind;
            end
            osl_pkg::MODE_PENDING: begin
                a_v = 1'b1;
                a_k = osl_pkg::op_kind(r_op, is_eq);
                b_v = !is_eq && sc.emit;
                b_k = sc.kind;
            end
            osl_pkg::MODE_STRING: begin
                a_v = is_quote;
                a_k = osl_pkg::KIND_STRING;
            end
            osl_pkg::MODE_DROP: a_v = 1'b0;
            default: a_v = 1'b0;
        endcase
        c_v = i_end_of_source &&
              (m1 == osl_pkg::MODE_PENDING || m1 == osl_pkg::MODE_STRING);
        c_k = (m1 == osl_pkg::MODE_PENDING) ? osl_pkg::op_kind(p1, 1'b0)
                                            : osl_pkg::KIND_UNTERMINATED;

        o_push      = take && (a_v || b_v || c_v);
        o_ctl.kind0 = a_v ? a_k : (b_v ? b_k : c_k);
        o_ctl.kind1 = (a_v && b_v) ? b_k : c_k;
        o_ctl.two   = (a_v && b_v) || (a_v && c_v) || (b_v && c_v);
        o_line      = (r_mode == osl_pkg::MODE_STRING) ? l1 : r_line;
        o_length    = (r_mode == osl_pkg::MODE_STRING && is_quote) ? r_cnt : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= osl_pkg::MODE_NORMAL;
            r_op   <= osl_pkg::OP_BANG;
            r_line <= LINE_WIDTH'(1);
            r_cnt  <= '0;
        end else if (take) begin
            r_mode <= n_mode;
            r_op   <= n_op;
            r_line <= n_line;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> sv/osl_queue.sv
// ----------------------------------------------------------------------------
// osl_queue
// Short first-in first-out queue of words between the scanner front end
// and the token output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module osl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = osl_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_space,
    output logic                  o_avail,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_space = (r_cnt != CW'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_next(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_next(r_rp);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/osl_back.sv
// ----------------------------------------------------------------------------
// osl_back
// Token output stage: takes queued words apart into single tokens and
// holds each in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module osl_back #(
    parameter int LINE_WIDTH   = osl_pkg::LINE_WIDTH_DEF,
    parameter int LENGTH_WIDTH = osl_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_avail,
    input  osl_pkg::t_ctl                i_ctl,
    input  wire logic [LINE_WIDTH-1:0]   i_line,
    input  wire logic [LENGTH_WIDTH-1:0] i_length,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [4:0]                   o_token_kind,
    output logic [LINE_WIDTH-1:0]        o_line_number,
    output logic [LENGTH_WIDTH-1:0]      o_string_length,
    output logic                         o_last_of_run
);

    logic                    r_valid, r_idx, r_last;
    osl_pkg::t_kind          r_kind;
    logic [LINE_WIDTH-1:0]   r_line;
    logic [LENGTH_WIDTH-1:0] r_len;
    logic                    load;

    assign load  = i_avail && (!r_valid || i_ready);
    assign o_pop = load && (!i_ctl.two || r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                r_idx <= 1'b0;
            end else if (load) begin
                r_idx <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= r_idx ? i_ctl.kind1 : i_ctl.kind0;
            r_line <= i_line;
            r_len  <= r_idx ? '0 : i_length;
            r_last <= !i_ctl.two || r_idx;
        end
    end

    assign o_valid         = r_valid;
    assign o_token_kind    = r_kind;
    assign o_line_number   = r_line;
    assign o_string_length = r_len;
    assign o_last_of_run   = r_last;

endmodule

`default_nettype wire
